// ----- rtl/assert_macros.svh -----
// assertion macros shared by the gzip header parser rtl
// no dependencies; modules that check themselves include this file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/gzhp_pkg.sv -----
// types, codes and constants of the gzip header parser
// no dependencies; used by every rtl module of the block
`default_nettype none

package gzhp_pkg;

    // output queue geometry
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    // config port
    localparam int unsigned CFG_IW = 3;
    localparam int unsigned CFG_DW = 8;

    typedef enum logic [CFG_IW-1:0] {
        CFG_STD_FIRST     = 3'd0,
        CFG_STD_SECOND    = 3'd1,
        CFG_CRC_ON_FIRST  = 3'd2,
        CFG_CRC_ON_SECOND = 3'd3,
        CFG_CRC_OFF_FIRST = 3'd4,
        CFG_CRC_OFF_SECOND = 3'd5
    } cfg_idx_t;

    localparam logic [7:0] RST_STD_FIRST  = 8'd31;
    localparam logic [7:0] RST_STD_SECOND = 8'd139;

    // header constants
    localparam logic [7:0]  FLG_RESERVED = 8'hE0;
    localparam logic [7:0]  FLG_EXTRA    = 8'h04;
    localparam logic [7:0]  FLG_NAME     = 8'h08;
    localparam logic [7:0]  FLG_COMMENT  = 8'h10;
    localparam logic [7:0]  FLG_HCRC     = 8'h02;
    localparam logic [15:0] METHOD_DEFLATE = 16'd8;
    localparam logic [15:0] FIXED_SKIP     = 16'd6;
    localparam logic [15:0] HCRC_LEN       = 16'd2;

    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_END  = 2'd1,
        OP_NEXT = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        PH_MAGIC1  = 4'd0,
        PH_MAGIC2  = 4'd1,
        PH_METHOD  = 4'd2,
        PH_FLAGS   = 4'd3,
        PH_SKIP6   = 4'd4,
        PH_XLEN_LO = 4'd5,
        PH_XLEN_HI = 4'd6,
        PH_XDATA   = 4'd7,
        PH_NAME    = 4'd8,
        PH_COMMENT = 4'd9,
        PH_HCRC    = 4'd10,
        PH_PAYLOAD = 4'd11,
        PH_TRANSP  = 4'd12,
        PH_HALT    = 4'd13
    } phase_t;

    typedef enum logic [2:0] {
        MODE_UNDECIDED = 3'd0,
        MODE_TRANSP    = 3'd1,
        MODE_STD       = 3'd2,
        MODE_CRC_ON    = 3'd3,
        MODE_CRC_OFF   = 3'd4
    } mode_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [2:0] stream_mode;
        logic       header_done;
        logic       data_error;
        logic       last_of_run;
    } result_t;

    // magic byte pairs held by the config registers
    typedef struct packed {
        logic [7:0] std_first;
        logic [7:0] std_second;
        logic [7:0] crc_on_first;
        logic [7:0] crc_on_second;
        logic [7:0] crc_off_first;
        logic [7:0] crc_off_second;
    } magic_cfg_t;

    // results of one processed item, written into the output queue
    typedef struct packed {
        logic    valid;
        logic    two;
        result_t first;
        result_t second;
    } push_t;

endpackage

`default_nettype wire

// ----- rtl/gzhp_parser.sv -----
// header parse state and per-byte phase logic of the gzip header parser
// depends on gzhp_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module gzhp_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire gzhp_pkg::item_t    item,
    input  wire gzhp_pkg::magic_cfg_t cfg,
    output gzhp_pkg::push_t         push
);

    // optional section stages
    localparam logic [2:0] SEC_EXTRA   = 3'd0;
    localparam logic [2:0] SEC_NAME    = 3'd1;
    localparam logic [2:0] SEC_COMMENT = 3'd2;
    localparam logic [2:0] SEC_HCRC    = 3'd3;
    localparam logic [2:0] SEC_DONE    = 3'd4;

    gzhp_pkg::phase_t phase_reg, phase_next;
    gzhp_pkg::mode_t  mode_reg, mode_next;
    logic             first_reg, first_next;
    logic             err_reg, err_next;
    logic [7:0]       held_reg, held_next;
    logic [7:0]       flags_reg, flags_next;
    logic [15:0]      skip_reg, skip_next;

    logic             emit;
    logic [7:0]       emit_byte;
    logic             two;
    logic             done;

    // first optional section at or after the given stage
    function automatic gzhp_pkg::phase_t sect_phase(input logic [2:0] stage,
                                                    input logic [7:0] flg);
        gzhp_pkg::phase_t ph;
        ph = gzhp_pkg::PH_PAYLOAD;
        if (stage <= SEC_HCRC && (flg & gzhp_pkg::FLG_HCRC) != 8'd0)
            ph = gzhp_pkg::PH_HCRC;
        if (stage <= SEC_COMMENT && (flg & gzhp_pkg::FLG_COMMENT) != 8'd0)
            ph = gzhp_pkg::PH_COMMENT;
        if (stage <= SEC_NAME && (flg & gzhp_pkg::FLG_NAME) != 8'd0)
            ph = gzhp_pkg::PH_NAME;
        if (stage == SEC_EXTRA && (flg & gzhp_pkg::FLG_EXTRA) != 8'd0)
            ph = gzhp_pkg::PH_XLEN_LO;
        return ph;
    endfunction

    always_comb
    begin
        logic             sect;
        logic [2:0]       stage;
        logic [15:0]      dec;
        logic [15:0]      xlen;
        gzhp_pkg::phase_t sph;

        phase_next = phase_reg;
        mode_next  = mode_reg;
        first_next = first_reg;
        err_next   = err_reg;
        held_next  = held_reg;
        flags_next = flags_reg;
        skip_next  = skip_reg;
        emit       = 1'b0;
        emit_byte  = 8'd0;
        two        = 1'b0;
        done       = 1'b0;
        sect       = 1'b0;
        stage      = SEC_DONE;
        dec        = skip_reg - 16'd1;
        xlen       = skip_reg | {item.data_byte, 8'd0};
        sph        = gzhp_pkg::PH_PAYLOAD;

        case (item.operation)
            gzhp_pkg::OP_DATA:
            begin
                case (phase_reg)
                    gzhp_pkg::PH_MAGIC1:
                    begin
                        held_next  = item.data_byte;
                        phase_next = gzhp_pkg::PH_MAGIC2;
                    end
                    gzhp_pkg::PH_MAGIC2:
                    begin
                        if (held_reg == cfg.std_first && item.data_byte == cfg.std_second)
                        begin
                            mode_next  = gzhp_pkg::MODE_STD;
                            first_next = 1'b0;
                            phase_next = gzhp_pkg::PH_METHOD;
                        end
                        else if (held_reg == cfg.crc_on_first &&
                                 item.data_byte == cfg.crc_on_second)
                        begin
                            mode_next  = gzhp_pkg::MODE_CRC_ON;
                            first_next = 1'b0;
                            phase_next = gzhp_pkg::PH_METHOD;
                        end
                        else if (held_reg == cfg.crc_off_first &&
                                 item.data_byte == cfg.crc_off_second)
                        begin
                            mode_next  = gzhp_pkg::MODE_CRC_OFF;
                            first_next = 1'b0;
                            phase_next = gzhp_pkg::PH_METHOD;
                        end
                        else if (first_reg)
                        begin
                            // fall back to pass-through, replay both bytes
                            mode_next  = gzhp_pkg::MODE_TRANSP;
                            first_next = 1'b0;
                            phase_next = gzhp_pkg::PH_TRANSP;
                            two        = 1'b1;
                        end
                        else
                        begin
                            err_next   = 1'b1;
                            phase_next = gzhp_pkg::PH_HALT;
                        end
                    end
                    gzhp_pkg::PH_METHOD:
                    begin
                        skip_next  = {8'd0, item.data_byte};
                        phase_next = gzhp_pkg::PH_FLAGS;
                    end
                    gzhp_pkg::PH_FLAGS:
                    begin
                        if (skip_reg != gzhp_pkg::METHOD_DEFLATE ||
                            (item.data_byte & gzhp_pkg::FLG_RESERVED) != 8'd0)
                        begin
                            err_next   = 1'b1;
                            phase_next = gzhp_pkg::PH_HALT;
                        end
                        else
                        begin
                            flags_next = item.data_byte;
                            skip_next  = gzhp_pkg::FIXED_SKIP;
                            phase_next = gzhp_pkg::PH_SKIP6;
                        end
                    end
                    gzhp_pkg::PH_SKIP6:
                    begin
                        skip_next = dec;
                        sect      = (dec == 16'd0);
                        stage     = SEC_EXTRA;
                    end
                    gzhp_pkg::PH_XLEN_LO:
                    begin
                        skip_next  = {8'd0, item.data_byte};
                        phase_next = gzhp_pkg::PH_XLEN_HI;
                    end
                    gzhp_pkg::PH_XLEN_HI:
                    begin
                        skip_next = xlen;
                        if (xlen == 16'd0)
                        begin
                            sect  = 1'b1;
                            stage = SEC_NAME;
                        end
                        else
                            phase_next = gzhp_pkg::PH_XDATA;
                    end
                    gzhp_pkg::PH_XDATA:
                    begin
                        skip_next = dec;
                        sect      = (dec == 16'd0);
                        stage     = SEC_NAME;
                    end
                    gzhp_pkg::PH_NAME:
                    begin
                        sect  = (item.data_byte == 8'd0);
                        stage = SEC_COMMENT;
                    end
                    gzhp_pkg::PH_COMMENT:
                    begin
                        sect  = (item.data_byte == 8'd0);
                        stage = SEC_HCRC;
                    end
                    gzhp_pkg::PH_HCRC:
                    begin
                        skip_next = dec;
                        sect      = (dec == 16'd0);
                        stage     = SEC_DONE;
                    end
                    gzhp_pkg::PH_PAYLOAD, gzhp_pkg::PH_TRANSP:
                    begin
                        emit      = 1'b1;
                        emit_byte = item.data_byte;
                    end
                    default:
                    begin
                        // halted: bytes are dropped
                    end
                endcase
            end
            gzhp_pkg::OP_END:
            begin
                case (phase_reg)
                    gzhp_pkg::PH_MAGIC1:
                    begin
                        if (first_reg)
                        begin
                            mode_next  = gzhp_pkg::MODE_TRANSP;
                            phase_next = gzhp_pkg::PH_TRANSP;
                        end
                    end
                    gzhp_pkg::PH_MAGIC2:
                    begin
                        if (first_reg)
                        begin
                            mode_next  = gzhp_pkg::MODE_TRANSP;
                            phase_next = gzhp_pkg::PH_TRANSP;
                            emit       = 1'b1;
                            emit_byte  = held_reg;
                        end
                        else
                        begin
                            err_next   = 1'b1;
                            phase_next = gzhp_pkg::PH_HALT;
                        end
                    end
                    gzhp_pkg::PH_PAYLOAD, gzhp_pkg::PH_TRANSP, gzhp_pkg::PH_HALT:
                    begin
                        // nothing to close
                    end
                    default:
                    begin
                        // truncated header
                        err_next   = 1'b1;
                        phase_next = gzhp_pkg::PH_HALT;
                    end
                endcase
            end
            gzhp_pkg::OP_NEXT:
            begin
                if (phase_reg == gzhp_pkg::PH_PAYLOAD)
                    phase_next = gzhp_pkg::PH_MAGIC1;
            end
            default:
            begin
                // unused code: one empty result
            end
        endcase

        if (sect)
        begin
            sph        = sect_phase(stage, flags_reg);
            phase_next = sph;
            done       = (sph == gzhp_pkg::PH_PAYLOAD);
            if (sph == gzhp_pkg::PH_HCRC)
                skip_next = gzhp_pkg::HCRC_LEN;
        end
    end

    always_comb
    begin
        push.valid = fire;
        push.two   = two;
        if (two)
        begin
            push.first.out_byte    = held_reg;
            push.first.out_valid   = 1'b1;
            push.first.last_of_run = 1'b0;
            push.second.out_byte   = item.data_byte;
        end
        else
        begin
            push.first.out_byte    = emit ? emit_byte : 8'd0;
            push.first.out_valid   = emit;
            push.first.last_of_run = 1'b1;
            push.second.out_byte   = 8'd0;
        end
        push.first.stream_mode  = mode_next;
        push.first.header_done  = done;
        push.first.data_error   = err_next;
        push.second.out_valid   = 1'b1;
        push.second.stream_mode = mode_next;
        push.second.header_done = 1'b0;
        push.second.data_error  = err_next;
        push.second.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gzhp_pkg::PH_MAGIC1;
            mode_reg  <= gzhp_pkg::MODE_UNDECIDED;
            first_reg <= 1'b1;
            err_reg   <= 1'b0;
            held_reg  <= 8'd0;
            flags_reg <= 8'd0;
            skip_reg  <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            first_reg <= first_next;
            err_reg   <= err_next;
            held_reg  <= held_next;
            flags_reg <= flags_next;
            skip_reg  <= skip_next;
        end
    end

    // error is sticky and parks the parser
    `ASSERT_NEXT(a_err_sticky, err_reg, err_reg)
    `ASSERT_ALWAYS(a_err_halts, !err_reg || phase_reg == gzhp_pkg::PH_HALT)
    // a byte replay only happens on the very first header's second byte
    `ASSERT_ALWAYS(a_two_first_hdr,
        !(fire && two) || (first_reg && phase_reg == gzhp_pkg::PH_MAGIC2))

endmodule

`default_nettype wire

// ----- rtl/gzhp_out_queue.sv -----
// small result queue of the gzip header parser, takes one or two results per cycle
// depends on gzhp_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module gzhp_out_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gzhp_pkg::push_t  push,
    output logic                  room,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output gzhp_pkg::result_t     result
);

    gzhp_pkg::result_t            mem [gzhp_pkg::QDEPTH];
    logic [gzhp_pkg::QAW-1:0]     wp_reg, wp_next;
    logic [gzhp_pkg::QAW-1:0]     rp_reg, rp_next;
    logic [gzhp_pkg::QCW-1:0]     count_reg, count_next;
    logic                         pop;
    logic [gzhp_pkg::QCW-1:0]     n_in;

    // room for a double transfer
    assign room         = (count_reg <= gzhp_pkg::QCW'(gzhp_pkg::QDEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result       = mem[rp_reg];
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        n_in       = push.valid ? (push.two ? gzhp_pkg::QCW'(2) : gzhp_pkg::QCW'(1)) : '0;
        wp_next    = wp_reg + gzhp_pkg::QAW'(n_in);
        rp_next    = pop ? rp_reg + gzhp_pkg::QAW'(1) : rp_reg;
        count_next = count_reg + n_in - (pop ? gzhp_pkg::QCW'(1) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wp_reg] <= push.first;
            if (push.two)
                mem[wp_reg + gzhp_pkg::QAW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, count_reg <= gzhp_pkg::QCW'(gzhp_pkg::QDEPTH))
    `ASSERT_ALWAYS(a_push_room, !push.valid || room)
    `ASSERT_NEXT(a_pop_only, pop && !push.valid,
        count_reg == $past(count_reg) - gzhp_pkg::QCW'(1))

endmodule

`default_nettype wire

// ----- rtl/gzip_header_parser.sv -----
// top level of the gzip member header parser: config registers, input register,
// parse logic and result queue; depends on gzhp_pkg, gzhp_parser, gzhp_out_queue
//
// usage
//   item channel: item_valid / item_stall / item carry one operation per transfer
//     (data byte, end of input, start next member)
//   result channel: result_valid / result_stall / result carry the results; every
//     item gives one result, a first-header magic mismatch gives two (held byte,
//     then current byte), the last of each run has last_of_run set
//   config: cfg_wr_en / cfg_index / cfg_wdata write the magic byte pairs; the user
//     writes only while the block is idle, not enforced; other indexes are ignored
// timing
//   an item transfer lands in the input register, is parsed once the queue has
//   room for two results and its results enter the four-entry queue, from which
//   they can transfer. one item per cycle is sustained while the queue has that
//   room, set by the single parse step between input register and queue
// stall
//   the item side is stalled while the input register holds an item and the queue
//   has fewer than two free entries; results wait in the queue, nothing is dropped
// reset
//   rst_n clears parse state to expect the first magic byte of the first header,
//   restores the default magic pairs and empties the queue
`default_nettype none

module gzip_header_parser (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gzhp_pkg::CFG_IW-1:0]     cfg_index,
    input  wire logic [gzhp_pkg::CFG_DW-1:0]     cfg_wdata,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire gzhp_pkg::item_t                 item,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output gzhp_pkg::result_t                    result
);

    gzhp_pkg::magic_cfg_t cfg_reg;
    gzhp_pkg::item_t      item_reg;
    logic                 item_vld_reg, item_vld_next;
    logic                 room;
    logic                 fire;
    logic                 take;
    gzhp_pkg::push_t      push;

    // held item is parsed once the queue can absorb a double result
    assign fire       = item_vld_reg && room;
    assign item_stall = item_vld_reg && !room;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        if (take)
            item_vld_next = 1'b1;
        else if (fire)
            item_vld_next = 1'b0;
        else
            item_vld_next = item_vld_reg;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else
            item_vld_reg <= item_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item;
    end

    // magic byte pair registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.std_first      <= gzhp_pkg::RST_STD_FIRST;
            cfg_reg.std_second     <= gzhp_pkg::RST_STD_SECOND;
            cfg_reg.crc_on_first   <= 8'd0;
            cfg_reg.crc_on_second  <= 8'd0;
            cfg_reg.crc_off_first  <= 8'd0;
            cfg_reg.crc_off_second <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gzhp_pkg::CFG_STD_FIRST:      cfg_reg.std_first      <= cfg_wdata;
                gzhp_pkg::CFG_STD_SECOND:     cfg_reg.std_second     <= cfg_wdata;
                gzhp_pkg::CFG_CRC_ON_FIRST:   cfg_reg.crc_on_first   <= cfg_wdata;
                gzhp_pkg::CFG_CRC_ON_SECOND:  cfg_reg.crc_on_second  <= cfg_wdata;
                gzhp_pkg::CFG_CRC_OFF_FIRST:  cfg_reg.crc_off_first  <= cfg_wdata;
                gzhp_pkg::CFG_CRC_OFF_SECOND: cfg_reg.crc_off_second <= cfg_wdata;
                default:
                begin
                    // unmapped index
                end
            endcase
        end
    end

    // one parse step per held item
    gzhp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .push  (push)
    );

    // result queue decouples the parse step from the receiver
    gzhp_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- tb/gzip_header_parser_check.sv -----
// result checker for the gzip header parser: follows the config port and both channels,
// predicts the results of every item transfer and compares them in order
// depends on gzhp_pkg
`timescale 1ns / 1ps

module gzip_header_parser_check
    import gzhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic              item_valid,
    input  logic              item_stall,
    input  item_t             item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  result_t           result,
    output int unsigned       fail_count,
    output int unsigned       pending
);

    // predicted parser state
    magic_cfg_t  magic;
    phase_t      phase;
    logic        first_hdr;
    logic [7:0]  held_magic;
    logic [7:0]  hdr_flags;
    logic [15:0] skip_cnt;
    mode_t       mode;
    logic        err;

    result_t expected_results[$];

    task automatic add_result(input logic [7:0] b, input logic valid, input logic done,
                              input logic last);
        result_t r;
        r.out_byte    = valid ? b : 8'h00;
        r.out_valid   = valid;
        r.stream_mode = mode;
        r.header_done = done;
        r.data_error  = err;
        r.last_of_run = last;
        expected_results.push_back(r);
    endtask

    task automatic halt_parser();
        err   = 1'b1;
        phase = PH_HALT;
    endtask

    // walk to the next optional header section; returns 1 when the header is complete
    function automatic logic next_section(input int unsigned stage);
        if (stage == 0 && (hdr_flags & FLG_EXTRA) != 0) begin
            phase = PH_XLEN_LO;
            return 1'b0;
        end
        if (stage <= 1 && (hdr_flags & FLG_NAME) != 0) begin
            phase = PH_NAME;
            return 1'b0;
        end
        if (stage <= 2 && (hdr_flags & FLG_COMMENT) != 0) begin
            phase = PH_COMMENT;
            return 1'b0;
        end
        if (stage <= 3 && (hdr_flags & FLG_HCRC) != 0) begin
            phase    = PH_HCRC;
            skip_cnt = HCRC_LEN;
            return 1'b0;
        end
        phase = PH_PAYLOAD;
        return 1'b1;
    endfunction

    task automatic parse_item(input item_t it);
        logic [7:0] b;
        logic       done;
        b    = it.data_byte;
        done = 1'b0;
        if (it.operation == OP_DATA) begin
            case (phase)
                PH_MAGIC1: begin
                    held_magic = b;
                    phase      = PH_MAGIC2;
                end
                PH_MAGIC2: begin
                    if (held_magic == magic.std_first && b == magic.std_second)
                        mode = MODE_STD;
                    else if (held_magic == magic.crc_on_first && b == magic.crc_on_second)
                        mode = MODE_CRC_ON;
                    else if (held_magic == magic.crc_off_first && b == magic.crc_off_second)
                        mode = MODE_CRC_OFF;
                    else if (first_hdr) begin
                        // not gzip at all: give back both bytes and pass everything on
                        mode      = MODE_TRANSP;
                        first_hdr = 1'b0;
                        phase     = PH_TRANSP;
                        add_result(held_magic, 1'b1, 1'b0, 1'b0);
                        add_result(b, 1'b1, 1'b0, 1'b1);
                        return;
                    end
                    else
                        halt_parser();
                    if (!err) begin
                        first_hdr = 1'b0;
                        phase     = PH_METHOD;
                    end
                end
                PH_METHOD: begin
                    skip_cnt = {8'h00, b};
                    phase    = PH_FLAGS;
                end
                PH_FLAGS: begin
                    if (skip_cnt != METHOD_DEFLATE || (b & FLG_RESERVED) != 0)
                        halt_parser();
                    else begin
                        hdr_flags = b;
                        skip_cnt  = FIXED_SKIP;
                        phase     = PH_SKIP6;
                    end
                end
                PH_SKIP6: begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 0) done = next_section(0);
                end
                PH_XLEN_LO: begin
                    skip_cnt = {8'h00, b};
                    phase    = PH_XLEN_HI;
                end
                PH_XLEN_HI: begin
                    skip_cnt = {b, skip_cnt[7:0]};
                    if (skip_cnt == 0) done = next_section(1);
                    else phase = PH_XDATA;
                end
                PH_XDATA: begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 0) done = next_section(1);
                end
                PH_NAME: begin
                    if (b == 8'h00) done = next_section(2);
                end
                PH_COMMENT: begin
                    if (b == 8'h00) done = next_section(3);
                end
                PH_HCRC: begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 0) done = next_section(4);
                end
                PH_PAYLOAD, PH_TRANSP: begin
                    add_result(b, 1'b1, 1'b0, 1'b1);
                    return;
                end
                default: ;
            endcase
        end
        else if (it.operation == OP_END) begin
            case (phase)
                PH_MAGIC1: begin
                    if (first_hdr) begin
                        mode  = MODE_TRANSP;
                        phase = PH_TRANSP;
                    end
                end
                PH_MAGIC2: begin
                    if (first_hdr) begin
                        mode  = MODE_TRANSP;
                        phase = PH_TRANSP;
                        add_result(held_magic, 1'b1, 1'b0, 1'b1);
                        return;
                    end
                    halt_parser();
                end
                PH_PAYLOAD, PH_TRANSP, PH_HALT: ;
                default: halt_parser();
            endcase
        end
        else if (it.operation == OP_NEXT) begin
            if (phase == PH_PAYLOAD) phase = PH_MAGIC1;
        end
        add_result(8'h00, 1'b0, done, 1'b1);
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0) begin
            $error("unexpected result transfer: out_byte %0d", got.out_byte);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("out_valid", want.out_valid, got.out_valid);
        check_field("stream_mode", want.stream_mode, got.stream_mode);
        check_field("header_done", want.header_done, got.header_done);
        check_field("data_error", want.data_error, got.data_error);
        check_field("last_of_run", want.last_of_run, got.last_of_run);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            magic            = '0;
            magic.std_first  = RST_STD_FIRST;
            magic.std_second = RST_STD_SECOND;
            phase            = PH_MAGIC1;
            first_hdr        = 1'b1;
            held_magic       = 8'h00;
            hdr_flags        = 8'h00;
            skip_cnt         = 16'h0000;
            mode             = MODE_UNDECIDED;
            err              = 1'b0;
            fail_count       = 0;
            expected_results.delete();
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_STD_FIRST:      magic.std_first      = cfg_wdata;
                    CFG_STD_SECOND:     magic.std_second     = cfg_wdata;
                    CFG_CRC_ON_FIRST:   magic.crc_on_first   = cfg_wdata;
                    CFG_CRC_ON_SECOND:  magic.crc_on_second  = cfg_wdata;
                    CFG_CRC_OFF_FIRST:  magic.crc_off_first  = cfg_wdata;
                    CFG_CRC_OFF_SECOND: magic.crc_off_second = cfg_wdata;
                    default: ;
                endcase
            end
            if (result_valid && !result_stall) check_result(result);
            if (item_valid && !item_stall) parse_item(item);
        end
        pending = expected_results.size();
    end

endmodule

// ----- tb/gzip_header_parser_tb.sv -----
// testbench top for the gzip header parser: drives item, result-stall and config
// stimulus and gives the verdict; checking lives in gzip_header_parser_check
// depends on gzhp_pkg, gzip_header_parser and gzip_header_parser_check
`timescale 1ns / 1ps

module gzip_header_parser_tb;
    import gzhp_pkg::*;

    // operation code the block treats as a no-op
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    // item budget of the random part; each stretch runs past its share by about
    // one member, and the directed part and the tail bring the run to about 450
    localparam int unsigned RANDOM_ITEMS  = 240;
    localparam int unsigned RANDOM_PHASES = 6;
    // a little more than the item-to-result latency of the block
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    cfg_idx_t          cfg_index    = CFG_STD_FIRST;
    logic [CFG_DW-1:0] cfg_wdata    = '0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    item_t             item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;

    int unsigned fail_count;
    int unsigned pending;

    // idling on both sides is enabled in stretches and switched off for the tail
    logic        idling     = 1'b1;
    int unsigned stall_left = 0;
    int unsigned cycles     = 0;
    int unsigned items_sent = 0;
    // copy of the magic pairs currently programmed, used to build headers
    magic_cfg_t  cur_magic;

    gzip_header_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    gzip_header_parser_check hdr_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog: a hang or a lost result ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("gzip_header_parser test failed");
            $finish;
        end
    end

    // receiver back-pressure in random bursts, only while idling is enabled
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(0, 11);
        end
        else
            result_stall <= 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // one item transfer; called right after a rising edge and returns right after
    // the edge that took the item; back-to-back calls keep valid high but for idle gaps
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        int unsigned gap;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{operation: op, data_byte: b};
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
    endtask

    // a header byte, sometimes preceded by an operation the parser must ignore
    // while inside a header (next member, unused code)
    task automatic header_byte(input logic [7:0] b);
        if ($urandom_range(0, 11) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                send_item(OP_NEXT, rand_byte());
            else
                send_item(OP_UNUSED, rand_byte());
        end
        send_item(OP_DATA, b);
    endtask

    // zero-terminated name or comment
    task automatic send_string();
        int unsigned n;
        n = $urandom_range(0, 6);
        repeat (n) header_byte(8'($urandom_range(1, 255)));
        header_byte(8'h00);
    endtask

    // stop sending and wait until every predicted result has come out, then let
    // the pipeline settle; pending is sampled on the falling edge
    task automatic drain();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    // only called while the block is idle
    task automatic program_magic(input magic_cfg_t m);
        write_reg(CFG_STD_FIRST, m.std_first);
        write_reg(CFG_STD_SECOND, m.std_second);
        write_reg(CFG_CRC_ON_FIRST, m.crc_on_first);
        write_reg(CFG_CRC_ON_SECOND, m.crc_on_second);
        write_reg(CFG_CRC_OFF_FIRST, m.crc_off_first);
        write_reg(CFG_CRC_OFF_SECOND, m.crc_off_second);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        cur_magic = m;
    endtask

    // a well-formed member with random optional sections and payload, closed by a
    // next-member transfer so the parser is back at the first magic byte
    task automatic send_member(input logic [7:0] m1, input logic [7:0] m2);
        logic [7:0]  flags;
        logic [15:0] xlen;
        int unsigned n;
        idling <= ($urandom_range(0, 4) != 0);
        // clean end of input between members, then a new header follows
        if ($urandom_range(0, 5) == 0) send_item(OP_END, rand_byte());
        flags = rand_byte() & ~FLG_RESERVED;
        header_byte(m1);
        header_byte(m2);
        header_byte(METHOD_DEFLATE[7:0]);
        header_byte(flags);
        repeat (FIXED_SKIP) header_byte(rand_byte());
        if ((flags & FLG_EXTRA) != 0)
        begin
            // mostly short extra fields, now and then one with a nonzero high byte
            if ($urandom_range(0, 19) == 0)
                xlen = 16'($urandom_range(256, 300));
            else
                xlen = 16'($urandom_range(0, 8));
            header_byte(xlen[7:0]);
            header_byte(xlen[15:8]);
            repeat (xlen) header_byte(rand_byte());
        end
        if ((flags & FLG_NAME) != 0) send_string();
        if ((flags & FLG_COMMENT) != 0) send_string();
        if ((flags & FLG_HCRC) != 0) repeat (HCRC_LEN) header_byte(rand_byte());
        n = $urandom_range(0, 12);
        repeat (n)
        begin
            // end of input and the unused code leave the payload untouched
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_item(OP_END, rand_byte());
                else
                    send_item(OP_UNUSED, rand_byte());
            end
            send_item(OP_DATA, rand_byte());
        end
        send_item(OP_NEXT, rand_byte());
    endtask

    initial
    begin
        int unsigned goal;
        int unsigned n;
        magic_cfg_t  m;
        logic [7:0]  b1;
        logic [7:0]  b2;

        cur_magic            = '0;
        cur_magic.std_first  = RST_STD_FIRST;
        cur_magic.std_second = RST_STD_SECOND;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one run in four starts with something that is not a gzip header, so the
        // block falls back to transparent mode and the rest of the run is passed on
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    // magic mismatch: both bytes come back
                    send_item(OP_DATA, RST_STD_FIRST);
                    send_item(OP_DATA, 8'h00);
                end
                1:
                begin
                    // end of input after a single byte
                    send_item(OP_DATA, RST_STD_FIRST);
                    send_item(OP_END, 8'h00);
                end
                default: send_item(OP_END, 8'h00);
            endcase
        end

        // directed part on the reset magic pairs
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_NEXT, 8'h00);
        send_item(OP_DATA, RST_STD_FIRST);
        send_item(OP_DATA, RST_STD_SECOND);
        send_item(OP_NEXT, 8'hFF);
        send_item(OP_DATA, METHOD_DEFLATE[7:0]);
        // every optional section plus the text bit
        send_item(OP_DATA, FLG_EXTRA | FLG_NAME | FLG_COMMENT | FLG_HCRC | 8'h01);
        repeat (3)
        begin
            send_item(OP_DATA, 8'h00);
            send_item(OP_DATA, 8'hFF);
        end
        // zero-length extra field
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'h80);
        send_item(OP_DATA, 8'h00);
        // empty comment
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_END, 8'h00);
        send_item(OP_NEXT, 8'h00);
        // clean end at the first magic byte of a later header
        send_item(OP_END, 8'hFF);

        // random part: several magic settings, all-zero and all-one among them
        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                drain();
                case (ph)
                    1: m = '0;
                    2: m = '1;
                    3: m = {RST_STD_FIRST, RST_STD_SECOND, 32'($urandom)};
                    default: m = {16'($urandom), 32'($urandom)};
                endcase
                program_magic(m);
            end
            goal = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < goal)
            begin
                case ($urandom_range(0, 2))
                    0: send_member(cur_magic.std_first, cur_magic.std_second);
                    1: send_member(cur_magic.crc_on_first, cur_magic.crc_on_second);
                    default: send_member(cur_magic.crc_off_first, cur_magic.crc_off_second);
                endcase
            end
        end

        // tail without idling: one broken header, after which the block halts
        idling <= 1'b0;
        drain();
        case ($urandom_range(0, 4))
            0:
            begin
                // method other than deflate
                send_item(OP_DATA, cur_magic.std_first);
                send_item(OP_DATA, cur_magic.std_second);
                b1 = rand_byte();
                if (b1 == METHOD_DEFLATE[7:0]) b1 = ~b1;
                send_item(OP_DATA, b1);
                send_item(OP_DATA, 8'h00);
            end
            1:
            begin
                // a reserved flag bit set
                send_item(OP_DATA, cur_magic.std_first);
                send_item(OP_DATA, cur_magic.std_second);
                send_item(OP_DATA, METHOD_DEFLATE[7:0]);
                send_item(OP_DATA, (rand_byte() & ~FLG_RESERVED)
                                   | (FLG_RESERVED & (8'h20 << $urandom_range(0, 2))));
            end
            2:
            begin
                // magic pair that matches none of the programmed pairs
                b1 = rand_byte();
                do
                    b2 = rand_byte();
                while (b2 == cur_magic.std_second || b2 == cur_magic.crc_on_second
                       || b2 == cur_magic.crc_off_second);
                send_item(OP_DATA, b1);
                send_item(OP_DATA, b2);
            end
            3:
            begin
                // end of input after one magic byte of a later header
                send_item(OP_DATA, cur_magic.std_first);
                send_item(OP_END, rand_byte());
            end
            default:
            begin
                // header cut short somewhere between method and extra length
                send_item(OP_DATA, cur_magic.std_first);
                send_item(OP_DATA, cur_magic.std_second);
                n = $urandom_range(0, 8);
                for (int unsigned i = 0; i < n; i++)
                begin
                    if (i == 0)
                        send_item(OP_DATA, METHOD_DEFLATE[7:0]);
                    else if (i == 1)
                        send_item(OP_DATA, FLG_EXTRA | FLG_NAME | FLG_COMMENT | FLG_HCRC);
                    else
                        send_item(OP_DATA, rand_byte());
                end
                send_item(OP_END, rand_byte());
            end
        endcase
        // anything after the error is dropped with the error flag held
        repeat (12) send_item(2'($urandom_range(0, 3)), rand_byte());
        drain();

        if (fail_count == 0)
            $display("gzip_header_parser test passed");
        else
            $display("gzip_header_parser test failed");
        $finish;
    end

endmodule
